// ===== sv/skrank_pkg.sv =====
// ----------------------------------------------------------------------------
// skrank_pkg
// Request codes and fixed widths shared by the sorted key table and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package skrank_pkg;

  localparam int unsigned ReqBits  = 2;
  localparam int unsigned LessBits = 8;

  typedef logic [ReqBits-1:0]  req_t;
  typedef logic [LessBits-1:0] less_t;

  localparam req_t ReqInsert = 2'd0;
  localparam req_t ReqMember = 2'd1;
  localparam req_t ReqRank   = 2'd2;
  localparam req_t ReqNone   = 2'd3;

  localparam less_t LessMax = 8'd255;

endpackage

`default_nettype wire

// ===== sv/sorted_key_table_rank.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_rank
// Sorted table of signed keys held in one memory: insert, membership, rank.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type_i and key_i with start_i high; the item is
//   taken at a clock edge where busy_o is low. busy_o stays high until the
//   result has been shown.
//   Result channel: done_o is high for exactly one cycle with found_o,
//   less_count_o and insert_rejected_o valid. The receiver cannot stall;
//   the result must be taken in that cycle.
//   The key memory (one read, one write port, registered read) is walked
//   linearly from the bottom until a key not less than the request key is
//   found or the stored keys run out. An accepted insert then shifts the
//   tail up one place, from the top down, and writes the key into the gap.
//   The unused request code answers with all zeros in the cycle after accept.
//   Only one item is in flight; the next is taken the cycle after done_o.
//   Reset: the table is empty; memory contents are not cleared, only entries
//   below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_rank #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned KEY_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output      logic                   busy_o,
  input  wire skrank_pkg::req_t       req_type_i,
  input  wire logic [KEY_BITS-1:0]    key_i,
  output      logic                   done_o,
  output      logic                   found_o,
  output      skrank_pkg::less_t      less_count_o,
  output      logic                   insert_rejected_o
);

  import skrank_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StShR  = 3'd4;
  localparam logic [2:0] StShW  = 3'd5;
  localparam logic [2:0] StResp = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       pos_q, pos_d;
  req_t                req_q, req_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                found_q, found_d;
  logic                rej_q, rej_d;

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rd_q;
  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_raddr, mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;

  logic [CW-1:0]       idx_dec;
  logic [31:0]         pos_w;

  assign idx_dec = idx_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    req_d     = req_q;
    key_d     = key_q;
    found_d   = found_q;
    rej_d     = rej_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = idx_q[AW-1:0];
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = rd_q;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          req_d   = req_type_i;
          key_d   = key_i;
          idx_d   = '0;
          pos_d   = '0;
          found_d = 1'b0;
          rej_d   = 1'b0;
          state_d = (req_type_i == ReqNone) ? StResp : StScan;
        end
      end
      StScan: begin
        if (idx_q == count_q) begin
          pos_d   = idx_q;
          state_d = StFin;
        end else begin
          mem_re  = 1'b1;
          state_d = StCmp;
        end
      end
      StCmp: begin
        if ($signed(rd_q) < $signed(key_q)) begin
          idx_d   = idx_q + CW'(1);
          state_d = StScan;
        end else begin
          pos_d   = idx_q;
          found_d = (rd_q == key_q);
          state_d = StFin;
        end
      end
      StFin: begin
        if (req_q == ReqInsert) begin
          if (count_q == CapCount) begin
            rej_d   = 1'b1;
            state_d = StResp;
          end else begin
            idx_d   = count_q;
            state_d = StShR;
          end
        end else begin
          state_d = StResp;
        end
      end
      StShR: begin
        if (idx_q == pos_q) begin
          mem_we    = 1'b1;
          mem_wdata = key_q;
          count_d   = count_q + CW'(1);
          state_d   = StResp;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_d   = StShW;
        end
      end
      StShW: begin
        mem_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = StShR;
      end
      StResp: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    req_q   <= req_d;
    key_q   <= key_d;
    found_q <= found_d;
    rej_q   <= rej_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign pos_w = 32'(pos_q);

  assign busy_o            = (state_q != StIdle);
  assign done_o            = (state_q == StResp);
  assign found_o           = found_q;
  assign less_count_o      = (pos_w > 32'(LessMax)) ? LessMax : pos_w[LessBits-1:0];
  assign insert_rejected_o = rej_q;

endmodule

`default_nettype wire

// ===== sv/skrank_checker.sv =====
// ----------------------------------------------------------------------------
// skrank_checker
// Port-level handshake and result checks on the sorted key table, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skrank_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire skrank_pkg::req_t  req_type_i,
  input wire logic              done_o,
  input wire logic              found_o,
  input wire skrank_pkg::less_t less_count_o,
  input wire logic              insert_rejected_o
);

  import skrank_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o low after an item was taken");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done_o outside a busy window");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !done_o))
    else $error("block not free after result");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == ReqNone) |=>
      (done_o && !found_o && less_count_o == '0 && !insert_rejected_o))
    else $error("unused request code gave a nonzero result");

endmodule

bind sorted_key_table_rank skrank_checker u_skrank_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .req_type_i        (req_type_i),
  .done_o            (done_o),
  .found_o           (found_o),
  .less_count_o      (less_count_o),
  .insert_rejected_o (insert_rejected_o)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_key_table_rank. Sends insert, membership,
// rank and unused requests through the start/busy handshake. A sorted copy of
// the table predicts each answer, and every done strobe is compared against it
// field by field. Random inserts are mixed with queries against hits, near
// misses and extremes, and inserts go on once the table is full.
// ----------------------------------------------------------------------------
module testbench;
  import skrank_pkg::*;

  localparam int unsigned Capacity    = 128;
  localparam int unsigned KeyBits     = 16;
  localparam int unsigned RandomItems = 1630;
  localparam int unsigned CycleLimit  = 5000000;

  typedef logic signed [KeyBits-1:0] key_t;

  typedef struct packed {
    logic  found;
    less_t less_count;
    logic  rejected;
  } answer_t;

  class key_table_model;
    key_t        stored_keys[$];
    answer_t     pending_answers[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string what);
      if (mismatches < 100) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    // answer reflects the table before this item
    function void note_request(req_t req, key_t k);
      answer_t     a;
      int unsigned below;
      a = '0;
      below = 0;
      if (req != ReqNone) begin
        foreach (stored_keys[i]) begin
          if (stored_keys[i] < k) below++;
          if (stored_keys[i] == k) a.found = 1'b1;
        end
        a.less_count = (below > LessMax) ? LessMax : less_t'(below);
        if (req == ReqInsert) begin
          if (stored_keys.size() >= Capacity) a.rejected = 1'b1;
          else stored_keys.insert(below, k);
        end
      end
      pending_answers.push_back(a);
    endfunction

    task check_answer(logic found, less_t less_count, logic rejected);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending_answers.pop_front();
      if (found !== want.found)
        report($sformatf("found got %b want %b", found, want.found));
      if (less_count !== want.less_count)
        report($sformatf("less_count got %0d want %0d", less_count, want.less_count));
      if (rejected !== want.rejected)
        report($sformatf("insert_rejected got %b want %b", rejected, want.rejected));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        start_i    = 1'b0;
  req_t        req_type_i = ReqNone;
  key_t        key_i      = '0;
  logic        busy_o;
  logic        done_o;
  logic        found_o;
  less_t       less_count_o;
  logic        insert_rejected_o;
  int unsigned cycles     = 0;
  bit          relaxed    = 1'b1;
  key_table_model model;

  sorted_key_table_rank #(
    .CAPACITY(Capacity),
    .KEY_BITS(KeyBits)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .key_i            (key_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .less_count_o     (less_count_o),
    .insert_rejected_o(insert_rejected_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) model.check_answer(found_o, less_count_o, insert_rejected_o);
  end

  // idle gaps are mostly short, sometimes long enough to land mid-walk
  task automatic send_request(req_t req, key_t k);
    int unsigned gap;
    gap = 0;
    if (relaxed) begin
      if ($urandom_range(99) < 3) gap = $urandom_range(300, 1);
      else while ($urandom_range(99) < 23) gap++;
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= req;
    key_i      <= k;
    do @(posedge clk_i); while (busy_o);
    model.note_request(req, k);
  endtask

  task automatic wait_for_answers();
    start_i <= 1'b0;
    while (model.pending_answers.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    key_t        k;
    req_t        req;
    int unsigned roll;
    int unsigned idx;
    int unsigned insert_odds;
    model = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused code, extremes and duplicates
    send_request(ReqMember, key_t'(0));
    send_request(ReqRank,   key_t'(32767));
    send_request(ReqNone,   key_t'(0));
    send_request(ReqInsert, key_t'(0));
    send_request(ReqInsert, key_t'(-32768));
    send_request(ReqInsert, key_t'(32767));
    send_request(ReqInsert, key_t'(0));
    send_request(ReqInsert, key_t'(-1));
    send_request(ReqInsert, key_t'(1));
    send_request(ReqMember, key_t'(0));
    send_request(ReqMember, key_t'(2));
    send_request(ReqRank,   key_t'(0));
    send_request(ReqRank,   key_t'(-32768));
    send_request(ReqRank,   key_t'(32767));
    send_request(ReqMember, key_t'(-32768));
    send_request(ReqMember, key_t'(32767));
    send_request(ReqRank,   key_t'(-32767));
    send_request(ReqNone,   key_t'(-1));
    send_request(ReqInsert, key_t'(32767));
    send_request(ReqInsert, key_t'(-32768));
    send_request(ReqRank,   key_t'(32767));
    wait_for_answers();

    for (int n = 0; n < RandomItems; n++) begin
      relaxed = !(n >= 700 && n < 1000);
      if (n == 1100) wait_for_answers();
      roll = $urandom_range(99);
      if (model.stored_keys.size() != 0 && roll < 45) begin
        idx = $urandom_range(model.stored_keys.size() - 1);
        k = model.stored_keys[idx];
        if (roll >= 30) k = $urandom_range(1) ? k + key_t'(1) : k - key_t'(1);
      end else if (roll < 65) begin
        k = key_t'($urandom_range(16)) - key_t'(8);
      end else if (roll < 75) begin
        case ($urandom_range(3))
          0:       k = 16'h8000;
          1:       k = 16'h7FFF;
          2:       k = 16'h8001;
          default: k = 16'hFFFF;
        endcase
      end else begin
        k = key_t'($urandom);
      end
      insert_odds = (model.stored_keys.size() < Capacity) ? 55 : 20;
      roll = $urandom_range(99);
      if (roll < 5) req = ReqNone;
      else if (roll < insert_odds) req = ReqInsert;
      else if (roll % 2 == 0) req = ReqMember;
      else req = ReqRank;
      send_request(req, k);
    end

    wait_for_answers();
    repeat (8) @(posedge clk_i);
    if (model.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
